// ===== rtl/amcd_pkg.sv =====
// Package for the AVI movi chunk demultiplexer: parse phases, result codes,
// result and push types. No dependencies.
package amcd_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PASS   = 2'd1,
        PH_SKIP   = 2'd2,
        PH_PAD    = 2'd3
    } amcd_phase_t;

    localparam logic [1:0] WHAT_BYTE  = 2'd0;
    localparam logic [1:0] WHAT_EMPTY = 2'd1;
    localparam logic [1:0] WHAT_END   = 2'd2;

    localparam logic       TYPE_VIDEO = 1'b0;
    localparam logic       TYPE_AUDIO = 1'b1;

    localparam logic [7:0] CHAR_D = 8'h64;
    localparam logic [7:0] CHAR_C = 8'h63;
    localparam logic [7:0] CHAR_B = 8'h62;
    localparam logic [7:0] CHAR_W = 8'h77;

    localparam logic [31:0] MAX_CHUNK_RESET = 32'd102400;

    localparam int          PADDR_W     = 3;
    localparam logic        REG_MAX_SEL = 1'b0;

    typedef struct packed {
        logic [1:0]  what;
        logic        stream_type;
        logic [7:0]  data_out;
        logic [31:0] chunk_bytes;
        logic        first_of_chunk;
        logic        last_of_chunk;
    } amcd_result_t;

    typedef struct packed {
        logic [1:0]   count;
        amcd_result_t r0;
        amcd_result_t r1;
    } amcd_push_t;

endpackage

// ===== rtl/amcd_parser.sv =====
// Chunk header parser and payload tagger: holds the parse state and turns one
// byte into up to two results. Depends on amcd_pkg.
module amcd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic [7:0]           in_byte,
    input  logic                 in_end,
    input  logic [31:0]          max_chunk_bytes,
    output amcd_pkg::amcd_push_t push
);
    import amcd_pkg::*;

    logic [63:0]  header_shift_reg, header_shift_next;
    logic [2:0]   header_count_reg, header_count_next;
    amcd_phase_t  phase_reg, phase_next;
    logic [31:0]  bytes_left_reg, bytes_left_next;
    logic         chunk_type_reg, chunk_type_next;
    logic [31:0]  chunk_length_reg, chunk_length_next;
    logic         pad_pending_reg, pad_pending_next;

    logic [63:0]  shift_new;
    logic [7:0]   c3, c4;
    logic [31:0]  size;
    logic         video, audio, keep;
    amcd_result_t res_a, res_end;
    logic         has_a;

    assign shift_new = {in_byte, header_shift_reg[63:8]};
    assign c3        = shift_new[23:16];
    assign c4        = shift_new[31:24];
    assign size      = shift_new[63:32];
    assign video     = (c3 == CHAR_D) && ((c4 == CHAR_C) || (c4 == CHAR_B));
    assign audio     = (c3 == CHAR_W) && (c4 == CHAR_B);
    assign keep      = (size <= max_chunk_bytes) && (video || audio);

    always_comb begin
        header_shift_next = header_shift_reg;
        header_count_next = header_count_reg;
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        chunk_type_next   = chunk_type_reg;
        chunk_length_next = chunk_length_reg;
        pad_pending_next  = pad_pending_reg;
        res_a             = '0;
        has_a             = 1'b0;
        res_end           = '0;
        res_end.what      = WHAT_END;
        push              = '0;

        unique case (phase_reg)
            PH_HEADER: begin
                header_shift_next = shift_new;
                if (header_count_reg == 3'd7) begin
                    header_count_next = 3'd0;
                    chunk_length_next = size;
                    pad_pending_next  = size[0];
                    bytes_left_next   = size;
                    if (keep) begin
                        chunk_type_next = audio ? TYPE_AUDIO : TYPE_VIDEO;
                    end
                    if (size == 32'd0) begin
                        if (keep) begin
                            has_a                = 1'b1;
                            res_a.what           = WHAT_EMPTY;
                            res_a.stream_type    = chunk_type_next;
                            res_a.first_of_chunk = 1'b1;
                            res_a.last_of_chunk  = 1'b1;
                        end
                        phase_next = PH_HEADER;
                    end else begin
                        phase_next = keep ? PH_PASS : PH_SKIP;
                    end
                end else begin
                    header_count_next = header_count_reg + 3'd1;
                end
            end
            PH_PASS: begin
                has_a                = 1'b1;
                res_a.what           = WHAT_BYTE;
                res_a.stream_type    = chunk_type_reg;
                res_a.data_out       = in_byte;
                res_a.chunk_bytes    = chunk_length_reg;
                res_a.first_of_chunk = (bytes_left_reg == chunk_length_reg);
                res_a.last_of_chunk  = (bytes_left_reg == 32'd1);
                bytes_left_next      = bytes_left_reg - 32'd1;
                if (bytes_left_reg == 32'd1) begin
                    phase_next = pad_pending_reg ? PH_PAD : PH_HEADER;
                end
            end
            PH_SKIP: begin
                bytes_left_next = bytes_left_reg - 32'd1;
                if (bytes_left_reg == 32'd1) begin
                    phase_next = pad_pending_reg ? PH_PAD : PH_HEADER;
                end
            end
            PH_PAD: begin
                pad_pending_next = 1'b0;
                phase_next       = PH_HEADER;
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        if (in_end) begin
            header_shift_next = '0;
            header_count_next = 3'd0;
            phase_next        = PH_HEADER;
            bytes_left_next   = '0;
            pad_pending_next  = 1'b0;
        end

        if (has_a) begin
            push.r0    = res_a;
            push.r1    = res_end;
            push.count = in_end ? 2'd2 : 2'd1;
        end else begin
            push.r0    = res_end;
            push.count = in_end ? 2'd1 : 2'd0;
        end
        if (!fire) begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_shift_reg <= '0;
            header_count_reg <= '0;
            phase_reg        <= PH_HEADER;
            bytes_left_reg   <= '0;
            chunk_type_reg   <= 1'b0;
            chunk_length_reg <= '0;
            pad_pending_reg  <= 1'b0;
        end else if (fire) begin
            header_shift_reg <= header_shift_next;
            header_count_reg <= header_count_next;
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            chunk_type_reg   <= chunk_type_next;
            chunk_length_reg <= chunk_length_next;
            pad_pending_reg  <= pad_pending_next;
        end
    end

endmodule

// ===== rtl/amcd_out_fifo.sv =====
// Result queue: four entries, takes up to two results a cycle, hands out one.
// Depends on amcd_pkg.
module amcd_out_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  amcd_pkg::amcd_push_t   push,
    input  logic                   pop_ready,
    output logic                   head_valid,
    output amcd_pkg::amcd_result_t head,
    output logic                   room
);
    import amcd_pkg::*;

    amcd_result_t mem_reg [4];
    logic [1:0]   wr_ptr_reg, wr_ptr_next;
    logic [1:0]   rd_ptr_reg, rd_ptr_next;
    logic [2:0]   count_reg, count_next;
    logic         pop;
    logic [1:0]   wr_ptr_inc;

    assign head_valid = (count_reg != 3'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign room       = (count_reg <= 3'd2);
    assign pop        = head_valid && pop_ready;
    assign wr_ptr_inc = wr_ptr_reg + 2'd1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/avi_movi_chunk_demux_unit.sv =====
// Top level of the AVI movi chunk demultiplexer: input register, APB register,
// parser and result queue. Depends on amcd_pkg, amcd_parser, amcd_out_fifo.
//
// Channel  Dir  Handshake         Transaction
// s_       in   s_valid/s_ready   one movi list byte with list end mark
// m_       out  m_valid/m_ready   one tagged byte, empty chunk or end result
// apb      in   psel/penable      write/read of max_chunk_bytes
//
// One byte per cycle while the result queue has room; a transaction's results
// pass through the input register, then the result queue, before they leave.
// A byte marked as list end after payload adds a second result, so input
// stalls only when the four-entry result queue holds three or more results.
// Reset is synchronous and active low; max_chunk_bytes resets to 102400.
module avi_movi_chunk_demux_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_list_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_what,
    output logic                          m_stream_type,
    output logic [7:0]                    m_data_out,
    output logic [31:0]                   m_chunk_bytes,
    output logic                          m_first_of_chunk,
    output logic                          m_last_of_chunk,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [amcd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import amcd_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_end_reg;
    logic [31:0]  max_chunk_reg;
    logic         fire;
    logic         room;
    amcd_push_t   push;
    amcd_result_t head;

    assign pready  = 1'b1;
    assign prdata  = (paddr[PADDR_W-1] == REG_MAX_SEL) ? max_chunk_reg : 32'd0;
    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chunk_reg <= MAX_CHUNK_RESET;
        end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_MAX_SEL)) begin
            max_chunk_reg <= pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_list_end;
        end
    end

    amcd_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fire            (fire),
        .in_byte         (in_byte_reg),
        .in_end          (in_end_reg),
        .max_chunk_bytes (max_chunk_reg),
        .push            (push)
    );

    amcd_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop_ready  (m_ready),
        .head_valid (m_valid),
        .head       (head),
        .room       (room)
    );

    assign m_what           = head.what;
    assign m_stream_type    = head.stream_type;
    assign m_data_out       = head.data_out;
    assign m_chunk_bytes    = head.chunk_bytes;
    assign m_first_of_chunk = head.first_of_chunk;
    assign m_last_of_chunk  = head.last_of_chunk;

endmodule
